// ----- rtl/integer_stack_calculator_top_defines.svh -----
// Assertion macros used by the stack calculator RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when SYNTH is defined.
`ifndef INTEGER_STACK_CALCULATOR_TOP_DEFINES_SVH
`define INTEGER_STACK_CALCULATOR_TOP_DEFINES_SVH

`ifndef SYNTH

// Checked on every clock edge outside reset.
`define ISC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("isc assertion failed");

// Checked on every clock edge, during reset too.
`define ISC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("isc assertion failed");

`else

`define ISC_ASSERT(lbl, prop)
`define ISC_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ----- rtl/isc_pkg.sv -----
package isc_pkg;

  // Stack geometry.
  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  // Operation codes carried in req_type.
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP  = 3'd1;
  localparam logic [2:0] OP_ADD  = 3'd2;
  localparam logic [2:0] OP_SUB  = 3'd3;
  localparam logic [2:0] OP_MUL  = 3'd4;
  localparam logic [2:0] OP_DIV  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIVZERO   = 2'd3;

  // Request beat.
  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } isc_req_t;

  // Response beat.
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [1:0]               status;
    logic [6:0]               depth_after;
  } isc_rsp_t;

endpackage

// ----- rtl/isc_ram.sv -----
module isc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports with registered data; the data holds between reads.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/isc_div.sv -----
module isc_div
  import isc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DATA_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  logic              busy;
  logic [STEP_W-1:0] step_cnt;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic              neg;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;
  logic              fits;
  logic [DATA_W-1:0] dividend_mag;
  logic [DATA_W-1:0] divisor_mag;

  // Operand magnitudes; the most negative value maps to itself as unsigned.
  assign dividend_mag = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
  assign divisor_mag  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem, quo[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = ~diff[DATA_W];

  // Sign fix-up on the unsigned quotient; wraps for min / -1.
  assign quotient = neg ? (~quo + 1'b1) : quo;

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift together, one bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend_mag;
      dvs <= divisor_mag;
      neg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy) begin
      rem <= fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/integer_stack_calculator_top.sv -----
// Stack calculator for 32-bit two's complement integers.
// Request channel (req_valid, req_stall, req): each beat carries an operation
// (push, pop, add, subtract, multiply, divide) and a value used by push only.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one beat per request,
// in order, with the result value, a status code and the stack depth after
// the operation. On any error the stack is left unchanged.
// Push, pop, add, subtract and unused codes respond straight from the
// registered read of the operand memory; multiply also registers the
// product before write-back, and divide waits for the one-bit-per-cycle
// divider. One request is in flight at a time: a new request is accepted
// only once the previous one has committed its response.
// Reset (rst, synchronous, active high) empties the stack and drops any
// pending response; memory contents are not cleared and need no sweep.
// A stalled response is held in the output register; the next request is
// still accepted and worked up to its write-back, which then waits until
// the output register frees.
`include "integer_stack_calculator_top_defines.svh"

module integer_stack_calculator_top
  import isc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  isc_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output isc_rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_WB
  } state_t;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  state_t            state;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  cnt_next;
  logic [2:0]        op_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] res_q;

  logic              accept;
  logic              out_free;
  logic              want_commit;
  logic              commit;
  logic [DATA_W-1:0] cm_res;
  logic [1:0]        cm_status;
  logic              want_we;
  logic              need_mul;
  logic              need_div;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] raddr_top;
  logic [ADDR_W-1:0] raddr_sec;
  logic [DATA_W-1:0] rd_top;
  logic [DATA_W-1:0] rd_sec;
  logic [DATA_W-1:0] mul_lo;
  logic              div_done;
  logic [DATA_W-1:0] div_quo;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // Top and second entries are read on acceptance. Writes only happen when a
  // response is committed, never in the idle state, so a read and a write
  // never meet in the same cycle.
  assign raddr_top = ADDR_W'(entry_count - 1'b1);
  assign raddr_sec = ADDR_W'(entry_count - CNT_TWO);

  isc_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (DATA_W),
    .AW    (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (accept),
    .raddr_a (raddr_top),
    .raddr_b (raddr_sec),
    .rdata_a (rd_top),
    .rdata_b (rd_sec)
  );

  // Low word of the product; registered into res_q before write-back.
  assign mul_lo = rd_sec * rd_top;

  isc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (need_div),
    .dividend (rd_sec),
    .divisor  (rd_top),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Operations whose result is registered in res_q before write-back: multiply and divide.
  assign need_mul = (state == S_READ) && (op_q == OP_MUL) && (entry_count >= CNT_TWO);
  assign need_div = (state == S_READ) && (op_q == OP_DIV) && (entry_count >= CNT_TWO)
                    && (rd_top != '0);

  // Outcome of the current item; it takes effect only when the output
  // register can accept the response.
  always_comb begin
    want_commit = 1'b0;
    want_we     = 1'b0;
    cm_res      = '0;
    cm_status   = ST_OK;
    cnt_next    = entry_count;
    ram_waddr   = raddr_sec;
    ram_wdata   = res_q;
    unique case (state)
      S_READ: begin
        want_commit = !(need_mul || need_div);
        unique case (op_q)
          OP_PUSH: begin
            ram_waddr = ADDR_W'(entry_count);
            ram_wdata = val_q;
            if (entry_count >= CNT_FULL) begin
              cm_status = ST_OVERFLOW;
            end else begin
              want_we  = 1'b1;
              cnt_next = entry_count + 1'b1;
            end
          end
          OP_POP: begin
            if (entry_count == '0) begin
              cm_status = ST_UNDERFLOW;
            end else begin
              cm_res   = rd_top;
              cnt_next = entry_count - 1'b1;
            end
          end
          OP_ADD, OP_SUB: begin
            if (entry_count < CNT_TWO) begin
              cm_status = ST_UNDERFLOW;
            end else begin
              cm_res    = (op_q == OP_ADD) ? (rd_sec + rd_top) : (rd_sec - rd_top);
              ram_wdata = cm_res;
              want_we   = 1'b1;
              cnt_next  = entry_count - 1'b1;
            end
          end
          OP_MUL, OP_DIV: begin
            if (entry_count < CNT_TWO) begin
              cm_status = ST_UNDERFLOW;
            end else if (op_q == OP_DIV && rd_top == '0) begin
              cm_status = ST_DIVZERO;
            end
          end
          default: begin
            // Unused operation codes leave everything as it is.
          end
        endcase
      end
      S_WB: begin
        want_commit = 1'b1;
        want_we     = 1'b1;
        cm_res      = res_q;
        cnt_next    = entry_count - 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign commit = want_commit && out_free;
  assign ram_we = want_we && commit;

  // Sequencer, entry count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (commit) begin
        rsp_valid       <= 1'b1;
        entry_count     <= cnt_next;
        rsp.result_value <= cm_res;
        rsp.status      <= cm_status;
        rsp.depth_after <= 7'(cnt_next);
      end
      if (accept) begin
        op_q  <= req.req_type;
        val_q <= req.push_value;
      end
      if (need_mul) begin
        res_q <= mul_lo;
      end else if (div_done) begin
        res_q <= div_quo;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (need_mul) begin
            state <= S_WB;
          end else if (need_div) begin
            state <= S_DIV;
          end else if (commit) begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WB;
          end
        end
        S_WB: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The stack never holds more entries than it has room for.
  `ISC_ASSERT_ALWAYS(a_count_bound, rst || (entry_count <= CNT_FULL))
  // The entry count only moves when a response is produced.
  `ISC_ASSERT(a_count_on_commit, !commit |=> $stable(entry_count))
  // The operand memory is never read and written in the same cycle.
  `ISC_ASSERT(a_no_rw_overlap, !(accept && ram_we))
  // The divider only finishes while the sequencer waits for it.
  `ISC_ASSERT(a_div_done_state, div_done |-> (state == S_DIV))

endmodule

// ----- tb/tb_integer_stack_calculator_top.sv -----
`timescale 1ns / 1ps

module tb_integer_stack_calculator_top
  import isc_pkg::*;
();

  // Request codes that the block treats as no operation.
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int RANDOM_OPS = 1000;
  localparam int CALM_OPS   = 150;
  localparam int DRAIN_WAIT = 60;

  // Random traffic runs in phases that push the stack toward full or empty.
  typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_kind_t;

  // Golden stack model plus the queue of response beats still owed by the block.
  class stack_scoreboard;
    logic [DATA_W-1:0] operand_mem [STACK_DEPTH];
    int                entry_total;
    isc_rsp_t          owed_rsp_q[$];
    int unsigned       failures;
    int unsigned       rsp_seen;

    function new();
      entry_total = 0;
      failures    = 0;
      rsp_seen    = 0;
    endfunction

    function int pending();
      return owed_rsp_q.size();
    endfunction

    // Apply one accepted request to the model and queue the response it owes.
    function void note_request(isc_req_t item);
      isc_rsp_t          owed;
      logic [DATA_W-1:0] top_val;
      logic [DATA_W-1:0] second_val;
      logic [DATA_W-1:0] outcome;
      logic [DATA_W-1:0] mag_num;
      logic [DATA_W-1:0] mag_den;
      logic [1:0]        code;
      code    = ST_OK;
      outcome = '0;
      case (item.req_type)
        OP_PUSH: begin
          if (entry_total >= STACK_DEPTH) begin
            code = ST_OVERFLOW;
          end else begin
            operand_mem[entry_total] = item.push_value;
            entry_total++;
          end
        end
        OP_POP: begin
          if (entry_total == 0) begin
            code = ST_UNDERFLOW;
          end else begin
            entry_total--;
            outcome = operand_mem[entry_total];
          end
        end
        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
          if (entry_total < 2) begin
            code = ST_UNDERFLOW;
          end else begin
            top_val    = operand_mem[entry_total - 1];
            second_val = operand_mem[entry_total - 2];
            case (item.req_type)
              OP_ADD: outcome = second_val + top_val;
              OP_SUB: outcome = second_val - top_val;
              OP_MUL: outcome = second_val * top_val;
              default: begin
                // Sign-magnitude division truncates toward zero; the
                // most negative value over minus one wraps back to itself.
                if (top_val == '0) begin
                  code = ST_DIVZERO;
                end else begin
                  mag_num = second_val[DATA_W-1] ? -second_val : second_val;
                  mag_den = top_val[DATA_W-1] ? -top_val : top_val;
                  outcome = mag_num / mag_den;
                  if (second_val[DATA_W-1] ^ top_val[DATA_W-1]) outcome = -outcome;
                end
              end
            endcase
            if (code == ST_OK) begin
              operand_mem[entry_total - 2] = outcome;
              entry_total--;
            end
          end
        end
        default: ;
      endcase
      owed.result_value = outcome;
      owed.status       = code;
      owed.depth_after  = entry_total[6:0];
      owed_rsp_q.push_back(owed);
    endfunction

    task report_failure(string msg);
      $display("[%0t] response beat %0d: %s", $time, rsp_seen, msg);
      failures++;
    endtask

    // Compare one accepted response beat with the oldest owed one.
    task check_response(isc_rsp_t got);
      isc_rsp_t owed;
      if (owed_rsp_q.size() == 0) begin
        report_failure("response with no request outstanding");
      end else begin
        owed = owed_rsp_q.pop_front();
        if (got.result_value !== owed.result_value)
          report_failure($sformatf("result_value got %0d expected %0d",
                                   got.result_value, owed.result_value));
        if (got.status !== owed.status)
          report_failure($sformatf("status got %0d expected %0d",
                                   got.status, owed.status));
        if (got.depth_after !== owed.depth_after)
          report_failure($sformatf("depth_after got %0d expected %0d",
                                   got.depth_after, owed.depth_after));
      end
      rsp_seen++;
    endtask
  endclass

  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  isc_req_t req       = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  isc_rsp_t rsp;

  bit calm_tail = 1'b0;
  bit gaps_on   = 1'b1;

  stack_scoreboard sb;

  integer_stack_calculator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one request beat, with an occasional idle burst ahead of it, and
  // return at the edge where it is taken. Valid stays high for a following beat.
  task automatic send_request(input isc_req_t item);
    if (!calm_tail && gaps_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(item);
  endtask

  task automatic send_op(input logic [2:0] op, input logic [DATA_W-1:0] value);
    isc_req_t item;
    item.req_type   = op;
    item.push_value = value;
    send_request(item);
  endtask

  // Operand values lean on the corners: zero, one, minus one and the extremes.
  function automatic logic [DATA_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0:       return '0;
      1:       return '1;
      2:       return {1'b1, {(DATA_W-1){1'b0}}};
      3:       return {1'b0, {(DATA_W-1){1'b1}}};
      4:       return 1;
      5, 6:    return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  function automatic isc_req_t pick_request(input phase_kind_t kind);
    isc_req_t item;
    int       roll;
    int       push_pct;
    int       arith;
    case (kind)
      FILL_PHASE:  push_pct = 85;
      DRAIN_PHASE: push_pct = 12;
      default:     push_pct = 50;
    endcase
    roll            = $urandom_range(0, 99);
    item.push_value = pick_value();
    if (roll < 4) begin
      item.req_type = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    end else if (roll < 4 + push_pct) begin
      item.req_type = OP_PUSH;
    end else begin
      arith = $urandom_range(0, 8);
      case (arith)
        0, 1:    item.req_type = OP_POP;
        2, 3:    item.req_type = OP_ADD;
        4, 5:    item.req_type = OP_SUB;
        6:       item.req_type = OP_MUL;
        default: item.req_type = OP_DIV;
      endcase
    end
    return item;
  endfunction

  // Directed opening: empty-stack errors, extremes, wrap cases, divide by zero.
  task automatic run_directed();
    send_op(OP_POP, $urandom);
    send_op(OP_ADD, $urandom);
    send_op(OP_PUSH, 32'h7fff_ffff);
    send_op(OP_SUB, $urandom);
    send_op(OP_DIV, $urandom);
    send_op(OP_MUL, $urandom);
    send_op(OP_PUSH, 32'h8000_0000);
    send_op(OP_ADD, $urandom);
    send_op(OP_PUSH, 32'h8000_0000);
    send_op(OP_PUSH, 32'hffff_ffff);
    send_op(OP_DIV, $urandom);
    send_op(OP_PUSH, 32'h0000_0000);
    send_op(OP_DIV, $urandom);
    send_op(OP_POP, $urandom);
    send_op(OP_MUL, $urandom);
    send_op(OP_PUSH, 32'd7);
    send_op(OP_PUSH, -32'sd3);
    send_op(OP_DIV, $urandom);
    send_op(OP_PUSH, 32'h7fff_ffff);
    send_op(OP_PUSH, 32'd1);
    send_op(OP_ADD, $urandom);
    send_op(OP_SUB, $urandom);
    send_op(OP_SPARE_A, $urandom);
    send_op(OP_SPARE_B, $urandom);
    send_op(OP_POP, $urandom);
    send_op(OP_POP, $urandom);
    send_op(OP_POP, $urandom);
  endtask

  // Random traffic in fill, drain and mixed phases; the last stretch runs flat out.
  task automatic run_random(input int total);
    int          real_ops;
    int          phase_left;
    phase_kind_t kind;
    isc_req_t    item;
    real_ops   = 0;
    phase_left = 0;
    kind       = MIXED_PHASE;
    while (real_ops < total) begin
      if (real_ops >= total - CALM_OPS) calm_tail = 1'b1;
      if (phase_left == 0) begin
        phase_left = $urandom_range(60, 160);
        kind       = phase_kind_t'($urandom_range(0, 2));
        gaps_on    = ($urandom_range(0, 3) != 0);
      end
      phase_left--;
      item = pick_request(kind);
      send_request(item);
      if (item.req_type != OP_SPARE_A && item.req_type != OP_SPARE_B) real_ops++;
    end
  endtask

  // Response side: random stall bursts separated by free stretches.
  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      if (!calm_tail) repeat ($urandom_range(0, 30)) @(posedge clk);
    end
  end

  // Check every response beat the block hands over.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
  end

  // Main sequence.
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(RANDOM_OPS);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.failures == 0) begin
      $display("[integer_stack_calculator_top] OK");
    end else begin
      $display("[integer_stack_calculator_top] ERROR");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("[integer_stack_calculator_top] ERROR");
    $finish;
  end

endmodule
